// ===== rtl/core/metronome_beat_controller_top_defines.svh =====
`ifndef METRONOME_BEAT_CONTROLLER_TOP_DEFINES_SVH
`define METRONOME_BEAT_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mbc_pkg.sv =====
package mbc_pkg;

    localparam int TICK_HZ = 64;
    localparam int BPM_MIN_I = 40;
    localparam int NUM = TICK_HZ * 60;
    localparam int NUM_W = $clog2(NUM + 1);
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int PER_W = $clog2(NUM / BPM_MIN_I + 1);
    localparam int CNT_W = $clog2(NUM / BPM_MIN_I + 2);

    localparam logic [7:0] BPM_DEFAULT = 8'd120;
    localparam logic [7:0] BPM_MIN = 8'(BPM_MIN_I);
    localparam logic [7:0] BPM_MAX = 8'd209;
    localparam logic [7:0] BPM_WRAP = 8'(BPM_MIN_I - BPM_MIN_I % 10);
    localparam logic [3:0] DIGIT_TOP = 4'd9;
    localparam logic [3:0] ONES_DEFAULT = 4'(120 % 10);

    localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(NUM / 120);
    localparam logic [7:0] PREM_RST = 8'(NUM % 120);

    typedef enum logic [3:0] {
        ACT_TICK       = 4'd0,
        ACT_ALARM_UP   = 4'd1,
        ACT_ALARM_LUP  = 4'd2,
        ACT_ALARM_LONG = 4'd3,
        ACT_LIGHT_UP   = 4'd4,
        ACT_LIGHT_LONG = 4'd5,
        ACT_TIMEOUT    = 4'd6,
        ACT_ACTIVATE   = 4'd7,
        ACT_RESIGN     = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        RATE_1HZ  = 2'd0,
        RATE_4HZ  = 2'd1,
        RATE_8HZ  = 2'd2,
        RATE_FULL = 2'd3
    } t_rate;

    typedef enum logic [1:0] {
        BLANK_NONE = 2'd0,
        BLANK_TENS = 2'd1,
        BLANK_ONES = 2'd2
    } t_blank;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_BEAT
    } t_state;

    typedef struct packed {
        logic [3:0] action;
        logic       alarm_held;
    } t_in_item;

    typedef struct packed {
        logic       beat;
        logic       beep_now;
        logic       phase;
        logic [7:0] bpm_value;
        logic       beep_enabled;
        logic       running;
        logic       setting_mode;
        logic       editing_ones;
        logic [1:0] blank_digits;
        logic [1:0] tick_rate;
    } t_out_item;

    typedef struct packed {
        logic [7:0] bpm;
        logic       run;
        logic       beep;
        logic       set;
        logic       scroll;
        logic       flash;
        logic       ones;
        t_rate      rate;
    } t_mode;

    typedef struct packed {
        logic recalc;
        logic restart;
        logic tick_run;
    } t_ctl;

endpackage

// ===== rtl/core/mbc_divider.sv =====
module mbc_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [7:0]               i_bpm,
    output logic                     o_done,
    output logic [mbc_pkg::PER_W-1:0] o_period,
    output logic [7:0]               o_prem
);
    import mbc_pkg::*;

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]  r_dvd;
    logic [NUM_W-1:0]  r_quo;
    logic [7:0]        r_rem;
    logic [7:0]        r_dsr;
    logic              r_done;
    logic [PER_W-1:0]  r_period;
    logic [7:0]        r_prem;

    logic [8:0]       w_trial;
    logic             w_fit;
    logic [7:0]       n_rem;
    logic [NUM_W-1:0] n_quo;

    always_comb begin
        w_trial = {r_rem, r_dvd[NUM_W-1]};
        w_fit = w_trial >= {1'b0, r_dsr};
        n_rem = w_fit ? 8'(w_trial - {1'b0, r_dsr}) : w_trial[7:0];
        n_quo = {r_quo[NUM_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_period <= PERIOD_RST;
            r_prem   <= PREM_RST;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W);
                r_dvd  <= NUM_W'(NUM);
                r_quo  <= '0;
                r_rem  <= '0;
                r_dsr  <= i_bpm;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[NUM_W-2:0], 1'b0};
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_period <= n_quo[PER_W-1:0];
                    r_prem   <= n_rem;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_period = r_period;
    assign o_prem   = r_prem;

endmodule

// ===== rtl/core/mbc_event.sv =====
module mbc_event (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mbc_pkg::t_in_item i_item,
    output mbc_pkg::t_mode    o_mode,
    output mbc_pkg::t_ctl     o_ctl
);
    import mbc_pkg::*;

    t_mode      r_mode;
    logic [3:0] r_ones_dig;
    t_ctl       r_ctl;

    t_mode      n_mode;
    logic [3:0] n_ones_dig;
    t_ctl       n_ctl;

    logic [8:0] w_tens_sum;
    logic [7:0] w_dstep_bpm;
    logic [3:0] w_dstep_ones;
    logic [7:0] w_inc_bpm;
    logic [3:0] w_inc_ones;
    logic [7:0] w_dec_bpm;
    logic [3:0] w_dec_ones;

    always_comb begin
        w_tens_sum = {1'b0, r_mode.bpm} + 9'd10;
        w_inc_bpm  = r_mode.bpm + 8'd1;
        w_inc_ones = (r_ones_dig == DIGIT_TOP) ? 4'd0 : r_ones_dig + 4'd1;
        w_dec_bpm  = r_mode.bpm - 8'd1;
        w_dec_ones = (r_ones_dig == 4'd0) ? DIGIT_TOP : r_ones_dig - 4'd1;
        if (!r_mode.ones) begin
            w_dstep_ones = r_ones_dig;
            if (w_tens_sum <= {1'b0, BPM_MAX}) begin
                w_dstep_bpm = w_tens_sum[7:0];
            end else begin
                w_dstep_bpm = BPM_WRAP + {4'd0, r_ones_dig};
            end
        end else if (r_ones_dig == DIGIT_TOP) begin
            w_dstep_bpm  = r_mode.bpm - {4'd0, DIGIT_TOP};
            w_dstep_ones = 4'd0;
        end else begin
            w_dstep_bpm  = w_inc_bpm;
            w_dstep_ones = w_inc_ones;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_ones_dig = r_ones_dig;
        n_ctl      = '0;
        case (t_action'(i_item.action))
            ACT_TICK: begin
                n_ctl.tick_run = r_mode.run;
                if (r_mode.set) begin
                    if (r_mode.scroll) begin
                        if (i_item.alarm_held) begin
                            n_mode.bpm   = w_dstep_bpm;
                            n_ones_dig   = w_dstep_ones;
                            n_ctl.recalc = 1'b1;
                        end
                    end else begin
                        n_mode.flash = !r_mode.flash;
                    end
                end
            end
            ACT_ALARM_UP: begin
                if (r_mode.set) begin
                    if (r_mode.scroll) begin
                        n_mode.scroll = 1'b0;
                        n_mode.rate   = RATE_4HZ;
                    end else begin
                        n_mode.bpm   = w_dstep_bpm;
                        n_ones_dig   = w_dstep_ones;
                        n_ctl.recalc = 1'b1;
                    end
                end else if (r_mode.bpm < BPM_MAX) begin
                    n_mode.bpm   = w_inc_bpm;
                    n_ones_dig   = w_inc_ones;
                    n_ctl.recalc = 1'b1;
                end
            end
            ACT_ALARM_LUP: begin
                if (r_mode.set && r_mode.scroll) begin
                    n_mode.scroll = 1'b0;
                    n_mode.rate   = RATE_4HZ;
                end
            end
            ACT_ALARM_LONG: begin
                if (r_mode.set) begin
                    if (!r_mode.scroll) begin
                        n_mode.scroll = 1'b1;
                        n_mode.flash  = 1'b0;
                        n_mode.rate   = RATE_8HZ;
                    end
                end else begin
                    n_mode.set    = 1'b1;
                    n_mode.flash  = 1'b0;
                    n_mode.scroll = 1'b0;
                    n_mode.ones   = 1'b0;
                    n_mode.run    = 1'b0;
                    n_mode.rate   = RATE_4HZ;
                end
            end
            ACT_LIGHT_UP: begin
                if (r_mode.set) begin
                    if (!r_mode.ones) begin
                        n_mode.ones = 1'b1;
                    end else begin
                        n_mode.set    = 1'b0;
                        n_mode.run    = 1'b1;
                        n_mode.rate   = RATE_FULL;
                        n_ctl.restart = 1'b1;
                    end
                end else if (r_mode.bpm > BPM_MIN) begin
                    n_mode.bpm   = w_dec_bpm;
                    n_ones_dig   = w_dec_ones;
                    n_ctl.recalc = 1'b1;
                end
            end
            ACT_LIGHT_LONG: begin
                if (r_mode.set) begin
                    n_mode.bpm   = BPM_DEFAULT;
                    n_ones_dig   = ONES_DEFAULT;
                    n_mode.ones  = 1'b0;
                    n_ctl.recalc = 1'b1;
                end else begin
                    n_mode.beep = !r_mode.beep;
                end
            end
            ACT_TIMEOUT: begin
                if (r_mode.set) begin
                    n_mode.set    = 1'b0;
                    n_mode.run    = 1'b1;
                    n_mode.rate   = RATE_FULL;
                    n_ctl.restart = 1'b1;
                end
            end
            ACT_ACTIVATE: begin
                n_mode.beep   = 1'b0;
                n_mode.run    = 1'b1;
                n_mode.rate   = RATE_FULL;
                n_ctl.restart = 1'b1;
            end
            ACT_RESIGN: begin
                n_mode.run  = 1'b0;
                n_mode.rate = RATE_1HZ;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode.bpm    <= BPM_DEFAULT;
            r_mode.run    <= 1'b0;
            r_mode.beep   <= 1'b0;
            r_mode.set    <= 1'b0;
            r_mode.scroll <= 1'b0;
            r_mode.flash  <= 1'b0;
            r_mode.ones   <= 1'b0;
            r_mode.rate   <= RATE_1HZ;
            r_ones_dig    <= ONES_DEFAULT;
            r_ctl         <= '0;
        end else if (i_load) begin
            r_mode     <= n_mode;
            r_ones_dig <= n_ones_dig;
            r_ctl      <= n_ctl;
        end
    end

    assign o_mode = r_mode;
    assign o_ctl  = r_ctl;

endmodule

// ===== rtl/core/mbc_beat.sv =====
module mbc_beat (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_restart,
    input  logic                      i_step,
    input  logic                      i_tick,
    input  logic [7:0]                i_bpm,
    input  logic [mbc_pkg::PER_W-1:0] i_period,
    input  logic [7:0]                i_prem,
    output logic                      o_beat,
    output logic                      o_phase
);
    import mbc_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_acc;
    logic             r_phase;
    logic             r_beat;

    logic [CNT_W-1:0] w_dec;
    logic             w_hit;
    logic [8:0]       w_sum;
    logic [8:0]       w_sub;
    logic             w_carry;
    logic [7:0]       n_acc;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        w_dec   = (r_count != '0) ? r_count - 1'b1 : '0;
        w_hit   = (w_dec == '0);
        w_sum   = {1'b0, r_acc} + {1'b0, i_prem};
        w_carry = w_sum >= {1'b0, i_bpm};
        w_sub   = w_sum - {1'b0, i_bpm};
        if (!w_carry) begin
            n_acc = w_sum[7:0];
        end else if (w_sub >= {1'b0, i_bpm}) begin
            n_acc = '0;
        end else begin
            n_acc = w_sub[7:0];
        end
        n_count = CNT_W'(i_period) + CNT_W'(w_carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_acc   <= '0;
            r_phase <= 1'b0;
            r_beat  <= 1'b0;
        end else if (i_restart) begin
            r_count <= CNT_W'(1);
            r_acc   <= '0;
            r_beat  <= 1'b0;
        end else if (i_step) begin
            r_beat <= i_tick && w_hit;
            if (i_tick) begin
                if (w_hit) begin
                    r_count <= n_count;
                    r_acc   <= n_acc;
                    r_phase <= !r_phase;
                end else begin
                    r_count <= w_dec;
                end
            end
        end
    end

    assign o_beat  = r_beat;
    assign o_phase = r_phase;

endmodule

// ===== rtl/core/metronome_beat_controller_top.sv =====
// Flow: an accepted item is registered in the event block, then ST_START;
// a bpm change adds a bit-serial divide in ST_DIV of NUM_W quotient bits
// (12 at TICK_HZ = 64), one bit per cycle; ST_BEAT loads the result when the
// output is not stalled. Input stalls until then, so items do not overlap.
// Reset: synchronous, active low; bpm 120, stopped, all mode flags clear.
`include "metronome_beat_controller_top_defines.svh"

module metronome_beat_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mbc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mbc_pkg::t_out_item o_out_data
);
    import mbc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic             w_accept;
    logic             w_div_start;
    logic             w_restart;
    logic             w_step;
    logic             w_load;
    logic             w_div_done;
    logic [PER_W-1:0] w_period;
    logic [7:0]       w_prem;
    logic             w_beat;
    logic             w_phase;
    t_mode            w_mode;
    t_ctl             w_ctl;
    t_out_item        w_res;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    mbc_event u_event (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_item  (i_in_data),
        .o_mode  (w_mode),
        .o_ctl   (w_ctl)
    );

    mbc_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_bpm    (w_mode.bpm),
        .o_done   (w_div_done),
        .o_period (w_period),
        .o_prem   (w_prem)
    );

    mbc_beat u_beat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_step    (w_step),
        .i_tick    (w_ctl.tick_run),
        .i_bpm     (w_mode.bpm),
        .i_period  (w_period),
        .i_prem    (w_prem),
        .o_beat    (w_beat),
        .o_phase   (w_phase)
    );

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_restart   = 1'b0;
        w_step      = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                w_restart   = w_ctl.restart;
                w_div_start = w_ctl.recalc;
                w_step      = !w_ctl.recalc;
                n_state     = w_ctl.recalc ? ST_DIV : ST_BEAT;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    w_step  = 1'b1;
                    n_state = ST_BEAT;
                end
            end
            ST_BEAT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_res.beat         = w_beat;
        w_res.beep_now     = w_beat && w_mode.beep;
        w_res.phase        = w_phase;
        w_res.bpm_value    = w_mode.bpm;
        w_res.beep_enabled = w_mode.beep;
        w_res.running      = w_mode.run;
        w_res.setting_mode = w_mode.set;
        w_res.editing_ones = w_mode.ones;
        w_res.tick_rate    = w_mode.rate;
        if (w_mode.set && !w_mode.scroll && !w_mode.flash) begin
            w_res.blank_digits = w_mode.ones ? BLANK_ONES : BLANK_TENS;
        end else begin
            w_res.blank_digits = BLANK_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `MBC_ASSERT_NOW(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "divide done outside wait")
    `MBC_ASSERT_NOW(a_bpm_range, i_clk, i_rst_n, o_out_valid, (o_out_data.bpm_value >= BPM_MIN) && (o_out_data.bpm_value <= BPM_MAX), "bpm out of range")
    `MBC_ASSERT_NOW(a_beat_running, i_clk, i_rst_n, o_out_valid && o_out_data.beat, o_out_data.running, "beat while stopped")
    `MBC_ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, w_accept, r_state == ST_START && o_in_stall, "accepted item not started")

endmodule

// ===== tb/sv/metronome_beat_controller_checker.sv =====
module metronome_beat_controller_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mbc_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mbc_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbc_pkg::*;

    localparam int TICKS_PER_MIN = TICK_HZ * 60;

    logic [7:0] bpm_now;
    logic [7:0] ticks_per_beat;
    logic [7:0] ticks_frac;
    logic [7:0] ticks_left;
    logic [8:0] frac_acc;
    logic       run_on;
    logic       beep_on;
    logic       tock;
    logic       set_on;
    logic       scroll_on;
    logic       flash_on;
    logic       ones_on;
    t_rate      rate_now;

    t_out_item  expected_results[$];

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        o_fail_count++;
    endtask

    task automatic recompute_period();
        ticks_per_beat = 8'(TICKS_PER_MIN / int'(bpm_now));
        ticks_frac     = 8'(TICKS_PER_MIN % int'(bpm_now));
    endtask

    task automatic clear_beat_state();
        bpm_now   = BPM_DEFAULT;
        recompute_period();
        ticks_left = '0;
        frac_acc  = '0;
        run_on    = 1'b0;
        beep_on   = 1'b0;
        tock      = 1'b0;
        set_on    = 1'b0;
        scroll_on = 1'b0;
        flash_on  = 1'b0;
        ones_on   = 1'b0;
        rate_now  = RATE_1HZ;
    endtask

    task automatic begin_run();
        run_on     = 1'b1;
        ticks_left = 8'd1;
        frac_acc   = '0;
        rate_now   = RATE_FULL;
    endtask

    task automatic end_run();
        rate_now = RATE_1HZ;
        run_on   = 1'b0;
    endtask

    task automatic exit_setting();
        set_on = 1'b0;
        begin_run();
    endtask

    task automatic bump_digit();
        if (!ones_on) begin
            if (int'(bpm_now) + 10 <= int'(BPM_MAX))
                bpm_now = bpm_now + 8'd10;
            else
                bpm_now = 8'(int'(BPM_MIN) - int'(BPM_MIN) % 10 + int'(bpm_now) % 10);
        end else begin
            if ((int'(bpm_now) + 1) % 10 != 0)
                bpm_now = bpm_now + 8'd1;
            else
                bpm_now = bpm_now - 8'd9;
        end
        recompute_period();
    endtask

    function automatic logic advance_beat();
        logic [8:0] acc;
        if (ticks_left != 0)
            ticks_left--;
        if (ticks_left != 0)
            return 1'b0;
        ticks_left = ticks_per_beat;
        acc = frac_acc + 9'(ticks_frac);
        if (acc >= 9'(bpm_now)) begin
            acc = acc - 9'(bpm_now);
            if (acc >= 9'(bpm_now))
                acc = '0;
            ticks_left++;
        end
        frac_acc = acc;
        tock = !tock;
        return 1'b1;
    endfunction

    task automatic predict_transfer(input t_in_item item, output t_out_item res);
        logic beat;
        beat = 1'b0;
        case (item.action)
            ACT_TICK: begin
                if (set_on) begin
                    if (scroll_on) begin
                        if (item.alarm_held)
                            bump_digit();
                    end else begin
                        flash_on = !flash_on;
                    end
                end
                if (run_on)
                    beat = advance_beat();
            end
            ACT_ALARM_UP: begin
                if (set_on) begin
                    if (scroll_on) begin
                        scroll_on = 1'b0;
                        rate_now  = RATE_4HZ;
                    end else begin
                        bump_digit();
                    end
                end else if (bpm_now < BPM_MAX) begin
                    bpm_now++;
                    recompute_period();
                end
            end
            ACT_ALARM_LUP: begin
                if (set_on && scroll_on) begin
                    scroll_on = 1'b0;
                    rate_now  = RATE_4HZ;
                end
            end
            ACT_ALARM_LONG: begin
                if (set_on) begin
                    if (!scroll_on) begin
                        scroll_on = 1'b1;
                        flash_on  = 1'b0;
                        rate_now  = RATE_8HZ;
                    end
                end else begin
                    set_on    = 1'b1;
                    flash_on  = 1'b0;
                    scroll_on = 1'b0;
                    ones_on   = 1'b0;
                    end_run();
                    rate_now  = RATE_4HZ;
                end
            end
            ACT_LIGHT_UP: begin
                if (set_on) begin
                    if (!ones_on)
                        ones_on = 1'b1;
                    else
                        exit_setting();
                end else if (bpm_now > BPM_MIN) begin
                    bpm_now--;
                    recompute_period();
                end
            end
            ACT_LIGHT_LONG: begin
                if (set_on) begin
                    bpm_now = BPM_DEFAULT;
                    recompute_period();
                    ones_on = 1'b0;
                end else begin
                    beep_on = !beep_on;
                end
            end
            ACT_TIMEOUT: begin
                if (set_on)
                    exit_setting();
            end
            ACT_ACTIVATE: begin
                run_on  = 1'b0;
                beep_on = 1'b0;
                if (bpm_now < BPM_MIN || bpm_now > BPM_MAX)
                    bpm_now = BPM_DEFAULT;
                recompute_period();
                begin_run();
            end
            ACT_RESIGN: end_run();
            default: ;
        endcase

        res.beat         = beat;
        res.beep_now     = beat && beep_on;
        res.phase        = tock;
        res.bpm_value    = bpm_now;
        res.beep_enabled = beep_on;
        res.running      = run_on;
        res.setting_mode = set_on;
        res.editing_ones = ones_on;
        if (set_on && !scroll_on && !flash_on)
            res.blank_digits = ones_on ? BLANK_ONES : BLANK_TENS;
        else
            res.blank_digits = BLANK_NONE;
        res.tick_rate    = rate_now;
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        if (got.beat !== want.beat)
            report_mismatch($sformatf("beat %b, want %b", got.beat, want.beat));
        if (got.beep_now !== want.beep_now)
            report_mismatch($sformatf("beep_now %b, want %b", got.beep_now, want.beep_now));
        if (got.phase !== want.phase)
            report_mismatch($sformatf("phase %b, want %b", got.phase, want.phase));
        if (got.bpm_value !== want.bpm_value)
            report_mismatch($sformatf("bpm_value %0d, want %0d", got.bpm_value,
                                      want.bpm_value));
        if (got.beep_enabled !== want.beep_enabled)
            report_mismatch($sformatf("beep_enabled %b, want %b", got.beep_enabled,
                                      want.beep_enabled));
        if (got.running !== want.running)
            report_mismatch($sformatf("running %b, want %b", got.running, want.running));
        if (got.setting_mode !== want.setting_mode)
            report_mismatch($sformatf("setting_mode %b, want %b", got.setting_mode,
                                      want.setting_mode));
        if (got.editing_ones !== want.editing_ones)
            report_mismatch($sformatf("editing_ones %b, want %b", got.editing_ones,
                                      want.editing_ones));
        if (got.blank_digits !== want.blank_digits)
            report_mismatch($sformatf("blank_digits %0d, want %0d", got.blank_digits,
                                      want.blank_digits));
        if (got.tick_rate !== want.tick_rate)
            report_mismatch($sformatf("tick_rate %0d, want %0d", got.tick_rate,
                                      want.tick_rate));
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_item want;
        if (!i_rst_n) begin
            clear_beat_state();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with none pending", i_out_data));
                end else begin
                    want = expected_results.pop_front();
                    compare_result(i_out_data, want);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_transfer(i_in_data, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/metronome_beat_controller_top_test.sv =====
module metronome_beat_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbc_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    logic        calm = 1'b0;
    int          fail_count;
    int          pending;
    int          n_sent = 0;
    int unsigned cycle_count = 0;

    always #1 clk = ~clk;

    metronome_beat_controller_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    metronome_beat_controller_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 34);

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_event(input logic [3:0] code, input logic held);
        t_in_item item;
        logic stalled;
        item.action     = code;
        item.alarm_held = held;
        while (!calm && $urandom_range(0, 99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        if (code <= ACT_RESIGN)
            n_sent++;
    endtask

    task automatic send_tick();
        send_event(ACT_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_step();
        case ($urandom_range(0, 2))
            0: send_event(ACT_ALARM_UP, 1'($urandom_range(0, 1)));
            1: send_event(ACT_LIGHT_UP, 1'($urandom_range(0, 1)));
            default: send_event(ACT_LIGHT_LONG, 1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_session();
        send_event(ACT_ACTIVATE, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1))
            send_event(ACT_LIGHT_LONG, 1'b0);
        repeat ($urandom_range(0, 3))
            send_step();
        repeat ($urandom_range(20, 90)) begin
            if ($urandom_range(0, 99) < 8)
                send_step();
            else
                send_tick();
        end
        if ($urandom_range(0, 1))
            send_event(ACT_RESIGN, 1'($urandom_range(0, 1)));
    endtask

    task automatic setting_session();
        int pick;
        send_event(ACT_ALARM_LONG, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(3, 15)) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_event(ACT_ALARM_UP, 1'($urandom_range(0, 1)));
            else if (pick < 60)
                send_tick();
            else if (pick < 65)
                send_event(ACT_LIGHT_LONG, 1'($urandom_range(0, 1)));
            else if (pick < 75) begin
                send_event(ACT_ALARM_LONG, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 12))
                    send_tick();
            end else if (pick < 85)
                send_event(ACT_ALARM_LUP, 1'($urandom_range(0, 1)));
            else if (pick < 95)
                send_event(ACT_LIGHT_UP, 1'($urandom_range(0, 1)));
            else
                send_event(ACT_TIMEOUT, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1)) begin
            send_event(ACT_TIMEOUT, 1'($urandom_range(0, 1)));
        end else begin
            send_event(ACT_LIGHT_UP, 1'($urandom_range(0, 1)));
            send_event(ACT_LIGHT_UP, 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(5, 40))
            send_tick();
    endtask

    // walk bpm toward one end, then beat there
    task automatic sweep_session();
        logic [3:0] code;
        code = $urandom_range(0, 1) ? ACT_ALARM_UP : ACT_LIGHT_UP;
        repeat ($urandom_range(20, 100))
            send_event(code, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(20, 60))
            send_tick();
    endtask

    initial begin : stimulus
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_event(ACT_TICK, 1'b0);
        send_event(4'd9, 1'b0);
        send_event(4'd15, 1'b1);
        send_event(ACT_RESIGN, 1'b0);
        send_event(ACT_ALARM_LUP, 1'b1);
        send_event(ACT_LIGHT_LONG, 1'b0);
        send_event(ACT_ACTIVATE, 1'b1);
        send_event(ACT_TICK, 1'b1);
        send_event(ACT_ALARM_UP, 1'b0);
        send_event(ACT_LIGHT_UP, 1'b0);
        send_event(ACT_ALARM_LONG, 1'b0);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_ACTIVATE, 1'b0);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_ALARM_LONG, 1'b1);
        send_event(ACT_TICK, 1'b1);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_ALARM_UP, 1'b1);
        send_event(ACT_ALARM_LONG, 1'b1);
        send_event(ACT_ALARM_LUP, 1'b0);
        send_event(ACT_LIGHT_LONG, 1'b1);
        send_event(ACT_LIGHT_UP, 1'b0);
        send_event(ACT_ALARM_UP, 1'b0);
        send_event(ACT_TIMEOUT, 1'b0);
        send_event(ACT_RESIGN, 1'b1);
        wait_drained();

        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            calm = (n_sent >= 600 && n_sent < 900);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                run_session();
            else if (pick < 70)
                setting_session();
            else if (pick < 80)
                sweep_session();
            else
                repeat ($urandom_range(1, 5))
                    send_event(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            if (pick == 0)
                wait_drained();
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
